[rtl/ttseu_pkg.sv]
`timescale 1ns / 1ps
package ttseu_pkg;

  // item kinds carried on the input tuser
  localparam logic [2:0] ACT_TICK_INT = 3'd0;
  localparam logic [2:0] ACT_TICK_EXT = 3'd1;
  localparam logic [2:0] ACT_STAGE    = 3'd2;
  localparam logic [2:0] ACT_COMMIT   = 3'd3;
  localparam logic [2:0] ACT_CONTROL  = 3'd4;

  // commit indexes that do something
  localparam logic [7:0] CMT_CTRL_AC  = 8'd0;
  localparam logic [7:0] CMT_CTRL_B   = 8'd1;
  localparam logic [7:0] CMT_LATCH_A  = 8'd3;
  localparam logic [7:0] CMT_LATCH_B  = 8'd5;
  localparam logic [7:0] CMT_LATCH_C  = 8'd7;

  // control byte bits
  localparam int unsigned CTL_ENABLE  = 7;
  localparam int unsigned CTL_CLK_INT = 1;
  localparam int unsigned CTL_LOW     = 0;

  localparam int unsigned NUM_TIMERS  = 3;
  localparam int unsigned NUM_SLOTS   = 8;
  localparam logic [4:0]  ENV_LAST    = 5'd16;
  localparam logic [4:0]  ENV_TOP     = 5'd17;

  typedef logic [15:0] cnt_t;
  typedef logic [7:0]  byte_t;

  // envelope volume table, 18 entries
  function automatic logic [6:0] vol_lut(input logic [4:0] idx);
    logic [6:0] v;
    case (idx)
      5'd5:    v = 7'd10;
      5'd6:    v = 7'd20;
      5'd7:    v = 7'd20;
      5'd8:    v = 7'd30;
      5'd9:    v = 7'd30;
      5'd10:   v = 7'd40;
      5'd11:   v = 7'd40;
      5'd12:   v = 7'd60;
      5'd13:   v = 7'd60;
      5'd14:   v = 7'd80;
      5'd15:   v = 7'd90;
      5'd16:   v = 7'd100;
      5'd17:   v = 7'd100;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/three_timer_sound_envelope_unit.sv]
`timescale 1ns / 1ps
// Three down-counting timers with a 17-step volume envelope driven by timer three.
// Each input word is one clock tick (internal or external), a staging byte write,
// a commit of staged bytes to a latch or control byte, or an envelope control
// byte; every input word yields exactly one output word showing the state after
// that action. The block takes one word per cycle while output words are taken:
// an accepted word is held in the input register while its state update and
// result are formed, and the result is registered in the output register,
// which drives m_axis_tvalid. Both registers stall together only when the
// output word is not taken. Output tdata fields, lowest bit first: timer_out_a,
// timer_out_b, timer_out_c, volume_level[6:0], envelope_step[4:0], envelope_up,
// noise_enable, noise_rate[4:0], held_in_reset, zero fill to 24 bits.
module three_timer_sound_envelope_unit
  import ttseu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // reg_index[2:0], byte_value[10:3], zero fill
  input  logic [2:0]  s_axis_tuser,   // action[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // timer_out_a, timer_out_b, timer_out_c,
                                      // volume_level[6:0], envelope_step[4:0],
                                      // envelope_up, noise_enable, noise_rate[4:0],
                                      // held_in_reset, zero fill
);

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  logic       in_vld_q;
  logic [2:0] in_act_q;
  logic [2:0] in_idx_q;
  byte_t      in_val_q;
  logic       out_vld_q;
  logic [23:0] out_data_q, out_data_d;

  logic adv;      // output register free to take the next result
  logic step_en;  // input word is processed this cycle

  assign adv           = !out_vld_q || m_axis_tready;
  assign step_en       = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_act_q <= s_axis_tuser;
      in_idx_q <= s_axis_tdata[2:0];
      in_val_q <= s_axis_tdata[10:3];
    end
  end

  // ---------------------------------------------------------------------------
  // block state
  // ---------------------------------------------------------------------------
  byte_t      stg_q  [NUM_SLOTS];
  byte_t      stg_d  [NUM_SLOTS];
  byte_t      ctrl_q [NUM_TIMERS];
  byte_t      ctrl_d [NUM_TIMERS];
  cnt_t       latch_q[NUM_TIMERS];
  cnt_t       latch_d[NUM_TIMERS];
  cnt_t       cnt_q  [NUM_TIMERS];
  cnt_t       cnt_d  [NUM_TIMERS];
  logic [2:0] lvl_q, lvl_d;
  logic [4:0] env_step_q, env_step_d;
  logic       env_up_q, env_up_d;
  logic       env_cont_q, env_cont_d;
  logic       env_alt_q, env_alt_d;
  logic       noise_on_q, noise_on_d;
  logic [4:0] noise_code_q, noise_code_d;
  logic       soft_q, soft_d;

  // tick and envelope helpers
  logic       tick_en;
  logic       tick_int;
  logic [2:0] fire;
  cnt_t       dec [NUM_TIMERS];
  logic       env_rise;
  logic [4:0] env_inc;
  logic [4:0] vol_idx;

  assign tick_en  = (in_act_q == ACT_TICK_INT) || (in_act_q == ACT_TICK_EXT);
  assign tick_int = (in_act_q == ACT_TICK_INT);

  always_comb begin
    stg_d        = stg_q;
    ctrl_d       = ctrl_q;
    latch_d      = latch_q;
    cnt_d        = cnt_q;
    lvl_d        = lvl_q;
    env_step_d   = env_step_q;
    env_up_d     = env_up_q;
    env_cont_d   = env_cont_q;
    env_alt_d    = env_alt_q;
    noise_on_d   = noise_on_q;
    noise_code_d = noise_code_q;
    soft_d       = soft_q;
    env_rise     = 1'b0;
    env_inc      = env_step_q;
    fire         = '0;

    // each timer counts on its own; a timer acts when enabled, clocked by this
    // tick kind and not held by the soft reset
    for (int i = 0; i < NUM_TIMERS; i++) begin
      dec[i] = (cnt_q[i] != '0) ? cnt_q[i] - 16'd1 : cnt_q[i];
      if (tick_en && ctrl_q[i][CTL_ENABLE] && !soft_q &&
          (ctrl_q[i][CTL_CLK_INT] == tick_int)) begin
        fire[i] = 1'b1;
      end
    end

    case (in_act_q)
      ACT_TICK_INT, ACT_TICK_EXT: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (fire[i]) begin
            cnt_d[i] = dec[i];
            if (dec[i] == '0 && latch_q[i] != '0) begin
              cnt_d[i] = latch_q[i];
              lvl_d[i] = ~lvl_q[i];
            end
          end
        end
        env_rise = lvl_d[2] && !lvl_q[2];
        // envelope advances on each rising edge of timer three
        if (env_rise) begin
          if (env_step_q != '0 && env_step_q <= ENV_LAST) begin
            env_inc = env_step_q + 5'd1;
          end
          env_step_d = env_inc;
          if (env_inc > ENV_LAST) begin
            if (!env_cont_q) begin
              if (!env_up_q) begin
                env_step_d = '0;
              end
            end else begin
              env_step_d = 5'd1;
              if (env_alt_q) begin
                env_up_d = ~env_up_q;
              end
            end
          end
        end
      end
      ACT_STAGE: begin
        stg_d[in_idx_q] = in_val_q;
      end
      ACT_COMMIT: begin
        case (in_val_q)
          CMT_LATCH_A: begin
            latch_d[0] = {stg_q[2], stg_q[3]};
            cnt_d[0]   = {stg_q[2], stg_q[3]};
          end
          CMT_LATCH_B: begin
            latch_d[1] = {stg_q[4], stg_q[5]};
            cnt_d[1]   = {stg_q[4], stg_q[5]};
          end
          CMT_LATCH_C: begin
            latch_d[2] = {stg_q[6], stg_q[7]};
            cnt_d[2]   = {stg_q[6], stg_q[7]};
          end
          CMT_CTRL_B: begin
            ctrl_d[1] = stg_q[1];
            lvl_d[1]  = 1'b0;
            if (!stg_q[1][CTL_ENABLE]) begin
              env_step_d = '0;
            end
          end
          CMT_CTRL_AC: begin
            // slot 0 goes to control one or control three by control two bit 0
            if (ctrl_q[1][CTL_LOW]) begin
              ctrl_d[0] = stg_q[0];
              soft_d    = stg_q[0][CTL_LOW];
              if (stg_q[0][CTL_LOW]) begin
                cnt_d = latch_q;
                lvl_d = '0;
              end
            end else begin
              ctrl_d[2] = stg_q[0];
            end
          end
          default: begin
          end
        endcase
      end
      ACT_CONTROL: begin
        noise_code_d = {1'b0, in_val_q[7:4]} + 5'd1;
        noise_on_d   = in_val_q[3];
        env_cont_d   = in_val_q[2];
        env_alt_d    = in_val_q[1];
        env_up_d     = in_val_q[0];
        env_step_d   = 5'd1;
      end
      default: begin
      end
    endcase
  end

  // volume from the table, read forward or backward by direction
  assign vol_idx = env_up_d ? env_step_d : (ENV_TOP - env_step_d);

  always_comb begin
    out_data_d        = '0;
    out_data_d[2:0]   = lvl_d;
    out_data_d[9:3]   = (env_step_d == '0) ? 7'd0 : vol_lut(vol_idx);
    out_data_d[14:10] = env_step_d;
    out_data_d[15]    = env_up_d;
    out_data_d[16]    = noise_on_d;
    out_data_d[21:17] = noise_code_d;
    out_data_d[22]    = soft_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        stg_q[i] <= '0;
      end
      for (int i = 0; i < NUM_TIMERS; i++) begin
        ctrl_q[i]  <= '0;
        latch_q[i] <= '0;
        cnt_q[i]   <= '0;
      end
      lvl_q        <= '0;
      env_step_q   <= '0;
      env_up_q     <= 1'b0;
      env_cont_q   <= 1'b0;
      env_alt_q    <= 1'b0;
      noise_on_q   <= 1'b0;
      noise_code_q <= '0;
      soft_q       <= 1'b0;
    end else if (step_en) begin
      stg_q        <= stg_d;
      ctrl_q       <= ctrl_d;
      latch_q      <= latch_d;
      cnt_q        <= cnt_d;
      lvl_q        <= lvl_d;
      env_step_q   <= env_step_d;
      env_up_q     <= env_up_d;
      env_cont_q   <= env_cont_d;
      env_alt_q    <= env_alt_d;
      noise_on_q   <= noise_on_d;
      noise_code_q <= noise_code_d;
      soft_q       <= soft_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // envelope never runs past its hold step
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_step_q <= ENV_TOP)
    else $error("envelope step out of range");

  // while held by soft reset no timer output can be high
  a_soft_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    soft_q |-> (lvl_q == 3'b000))
    else $error("timer output high during soft reset");

  // a processed word always shows up at the output next cycle
  a_word_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> m_axis_tvalid)
    else $error("processed word lost");

  // silent envelope reports zero volume
  a_silent_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[14:10] == 5'd0)) |-> (m_axis_tdata[9:3] == 7'd0))
    else $error("volume nonzero with silent envelope");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import ttseu_pkg::*;

  // item kinds with no effect on the block
  localparam logic [2:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [2:0] ACT_RSVD_LAST  = 3'd7;

  // envelope control byte bits
  localparam int unsigned ENV_NOISE_BIT = 3;
  localparam int unsigned ENV_CONT_BIT  = 2;
  localparam int unsigned ENV_ALT_BIT   = 1;
  localparam int unsigned ENV_UP_BIT    = 0;

  localparam int unsigned TARGET_WORDS  = 1925;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned IDLE_PCT      = 24;
  localparam int unsigned REPORT_MAX    = 10;

  // volume per envelope index, index 17 in the top slot
  localparam logic [17:0][6:0] VOL_STEPS = {
    7'd100, 7'd100, 7'd90, 7'd80, 7'd60, 7'd60, 7'd40, 7'd40, 7'd30,
    7'd30, 7'd20, 7'd20, 7'd10, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
  };

  typedef struct {
    logic [2:0] act;
    logic [2:0] slot;
    logic [7:0] val;
  } host_word_t;

  typedef struct {
    logic       out_a;
    logic       out_b;
    logic       out_c;
    logic [6:0] vol;
    logic [4:0] step;
    logic       up;
    logic       noise_en;
    logic [4:0] rate;
    logic       held;
  } sound_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  host_word_t  host_words_todo[$];
  sound_word_t sound_words_due[$];

  int unsigned cyc_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned useful_words = 0;
  logic        calm;

  // mirror of the block state
  byte_t      stage_mem[NUM_SLOTS];
  byte_t      ctl[NUM_TIMERS];
  cnt_t       latch[NUM_TIMERS];
  cnt_t       count[NUM_TIMERS];
  logic       lvl[NUM_TIMERS];
  logic [4:0] env_pos;
  logic       env_rise;
  logic       env_cont;
  logic       env_alt;
  logic       nz_on;
  logic [4:0] nz_code;
  logic       held;

  three_timer_sound_envelope_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // reg_index[2:0], byte_value[10:3], zero fill
    .s_axis_tuser  (s_axis_tuser),   // action[2:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // outs a/b/c, volume, step, up, noise, rate, held
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // no idling at all inside this window
  assign calm = (cyc_count >= 1000) && (cyc_count < 1800);

  // apply one accepted word to the mirror and queue the word the block must answer
  task automatic apply_host_word(input host_word_t w);
    sound_word_t exp_w;
    logic [1:0]  t;
    logic        want_int;
    logic [4:0]  vidx;
    case (w.act)
      ACT_TICK_INT, ACT_TICK_EXT: begin
        want_int = (w.act == ACT_TICK_INT);
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (ctl[i][CTL_CLK_INT] == want_int && ctl[i][CTL_ENABLE] && !held) begin
            if (count[i] != 0) count[i] = count[i] - 1'b1;
            if (count[i] == 0 && latch[i] != 0) begin
              count[i] = latch[i];
              lvl[i] = ~lvl[i];
              // rising output of timer three steps the envelope
              if (i == NUM_TIMERS - 1 && lvl[i]) begin
                if (env_pos >= 1 && env_pos <= ENV_LAST) env_pos = env_pos + 1'b1;
                if (env_pos > ENV_LAST) begin
                  if (!env_cont) begin
                    if (!env_rise) env_pos = '0;
                  end else begin
                    env_pos = 5'd1;
                    if (env_alt) env_rise = ~env_rise;
                  end
                end
              end
            end
          end
        end
      end
      ACT_STAGE: stage_mem[w.slot] = w.val;
      ACT_COMMIT: begin
        case (w.val)
          CMT_LATCH_A, CMT_LATCH_B, CMT_LATCH_C: begin
            t = w.val[2:1] - 2'd1;
            latch[t] = {stage_mem[w.val[2:0] - 3'd1], stage_mem[w.val[2:0]]};
            count[t] = latch[t];
          end
          CMT_CTRL_B: begin
            ctl[1] = stage_mem[1];
            if (!ctl[1][CTL_ENABLE]) env_pos = '0;
            lvl[1] = 1'b0;
          end
          CMT_CTRL_AC: begin
            // control b low bit steers the write to timer one or timer three
            if (ctl[1][CTL_LOW]) begin
              ctl[0] = stage_mem[0];
              held = ctl[0][CTL_LOW];
              if (held) begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                  count[i] = latch[i];
                  lvl[i] = 1'b0;
                end
              end
            end else begin
              ctl[2] = stage_mem[0];
            end
          end
          default: ;
        endcase
      end
      ACT_CONTROL: begin
        nz_code = {1'b0, w.val[7:4]} + 5'd1;
        nz_on = w.val[ENV_NOISE_BIT];
        env_cont = w.val[ENV_CONT_BIT];
        env_alt = w.val[ENV_ALT_BIT];
        env_rise = w.val[ENV_UP_BIT];
        env_pos = 5'd1;
      end
      default: ;
    endcase
    vidx = env_rise ? env_pos : ENV_TOP - env_pos;
    exp_w.out_a = lvl[0];
    exp_w.out_b = lvl[1];
    exp_w.out_c = lvl[2];
    exp_w.vol = (env_pos == 0) ? 7'd0 : VOL_STEPS[vidx];
    exp_w.step = env_pos;
    exp_w.up = env_rise;
    exp_w.noise_en = nz_on;
    exp_w.rate = nz_code;
    exp_w.held = held;
    sound_words_due.push_back(exp_w);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // queue a word for the driver; ignored words do not count toward the target
  task automatic add_word(input logic [2:0] act, input logic [2:0] slot,
                          input logic [7:0] val);
    host_word_t w;
    w.act = act;
    w.slot = slot;
    w.val = val;
    host_words_todo.push_back(w);
    if (act <= ACT_CONTROL && !(act == ACT_COMMIT && !(val == CMT_CTRL_AC ||
        val == CMT_CTRL_B || val == CMT_LATCH_A || val == CMT_LATCH_B ||
        val == CMT_LATCH_C)))
      useful_words++;
  endtask

  // stage a 16-bit value into the slot pair and commit it to a timer latch
  task automatic add_latch(input logic [7:0] cmt, input logic [15:0] value);
    add_word(ACT_STAGE, cmt[2:0] - 3'd1, value[15:8]);
    add_word(ACT_STAGE, cmt[2:0], value[7:0]);
    add_word(ACT_COMMIT, '0, cmt);
  endtask

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // driver: predicts on acceptance, then offers the next pending word
  always @(posedge clk_i) begin
    host_word_t acc;
    host_word_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.act = s_axis_tuser;
        acc.slot = s_axis_tdata[2:0];
        acc.val = s_axis_tdata[10:3];
        apply_host_word(acc);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (host_words_todo.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = host_words_todo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'b0, nxt.val, nxt.slot};
          s_axis_tuser <= nxt.act;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure and field-by-field compare
  always @(posedge clk_i) begin
    sound_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (m_axis_tvalid && m_axis_tready) begin
        if (sound_words_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected output word %h", m_axis_tdata);
        end else begin
          want = sound_words_due.pop_front();
          check_field("timer_out_a", 32'(want.out_a), 32'(m_axis_tdata[0]));
          check_field("timer_out_b", 32'(want.out_b), 32'(m_axis_tdata[1]));
          check_field("timer_out_c", 32'(want.out_c), 32'(m_axis_tdata[2]));
          check_field("volume_level", 32'(want.vol), 32'(m_axis_tdata[9:3]));
          check_field("envelope_step", 32'(want.step), 32'(m_axis_tdata[14:10]));
          check_field("envelope_up", 32'(want.up), 32'(m_axis_tdata[15]));
          check_field("noise_enable", 32'(want.noise_en), 32'(m_axis_tdata[16]));
          check_field("noise_rate", 32'(want.rate), 32'(m_axis_tdata[21:17]));
          check_field("held_in_reset", 32'(want.held), 32'(m_axis_tdata[22]));
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned burst;
    logic [2:0]  tick_kind;
    logic [7:0]  cmt;
    logic [15:0] value;
    logic [7:0]  ctl_byte;

    for (int i = 0; i < NUM_SLOTS; i++) stage_mem[i] = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      ctl[i] = '0;
      latch[i] = '0;
      count[i] = '0;
      lvl[i] = 1'b0;
    end
    env_pos = '0;
    env_rise = 1'b0;
    env_cont = 1'b0;
    env_alt = 1'b0;
    nz_on = 1'b0;
    nz_code = '0;
    held = 1'b0;

    // directed: undefined kinds, control byte extremes, soft reset hold,
    // no-op commit, silencing via control two, envelope run from timer three
    for (int a = ACT_RSVD_FIRST; a <= ACT_RSVD_LAST; a++)
      add_word(a[2:0], 3'd7, 8'hFF);
    add_word(ACT_CONTROL, 3'd0, 8'hFF);
    add_word(ACT_CONTROL, 3'd0, 8'h00);
    add_latch(CMT_LATCH_A, 16'h0001);
    add_word(ACT_STAGE, 3'd1, 8'h81);
    add_word(ACT_COMMIT, 3'd0, CMT_CTRL_B);
    add_word(ACT_STAGE, 3'd0, 8'h83);
    add_word(ACT_COMMIT, 3'd0, CMT_CTRL_AC);
    add_word(ACT_TICK_INT, 3'd0, 8'h00);
    add_word(ACT_STAGE, 3'd0, 8'h82);
    add_word(ACT_COMMIT, 3'd0, CMT_CTRL_AC);
    add_word(ACT_TICK_INT, 3'd0, 8'h00);
    add_word(ACT_COMMIT, 3'd0, 8'hFF);
    add_word(ACT_STAGE, 3'd1, 8'h00);
    add_word(ACT_COMMIT, 3'd0, CMT_CTRL_B);
    add_word(ACT_COMMIT, 3'd0, CMT_CTRL_AC);
    add_latch(CMT_LATCH_C, 16'h0001);
    add_word(ACT_CONTROL, 3'd0, 8'h07);
    add_word(ACT_TICK_INT, 3'd0, 8'h00);
    add_word(ACT_TICK_INT, 3'd0, 8'h00);
    add_word(ACT_TICK_EXT, 3'd0, 8'h00);

    // random: mostly setup sequences and tick bursts, some noise words
    while (useful_words < TARGET_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        burst = $urandom_range(40, 4);
        tick_kind = $urandom_range(1) ? ACT_TICK_INT : ACT_TICK_EXT;
        for (int i = 0; i < burst; i++) begin
          if ($urandom_range(99) < 25)
            tick_kind = (tick_kind == ACT_TICK_INT) ? ACT_TICK_EXT : ACT_TICK_INT;
          add_word(tick_kind, 3'($urandom_range(7)), 8'($urandom_range(255)));
        end
      end else if (pick < 55) begin
        case ($urandom_range(2))
          0:       cmt = CMT_LATCH_A;
          1:       cmt = CMT_LATCH_B;
          default: cmt = CMT_LATCH_C;
        endcase
        pick = $urandom_range(99);
        if (pick < 70)      value = 16'($urandom_range(6, 1));
        else if (pick < 80) value = '0;
        else                value = 16'($urandom_range(16'hFFFF));
        add_latch(cmt, value);
      end else if (pick < 70) begin
        ctl_byte = 8'($urandom_range(255));
        ctl_byte[CTL_ENABLE] = ($urandom_range(99) < 90);
        if ($urandom_range(1)) begin
          add_word(ACT_STAGE, 3'd1, ctl_byte);
          add_word(ACT_COMMIT, 3'($urandom_range(7)), CMT_CTRL_B);
        end else begin
          // soft reset only now and then so the timers mostly run
          ctl_byte[CTL_LOW] = ($urandom_range(99) < 20);
          add_word(ACT_STAGE, 3'd0, ctl_byte);
          add_word(ACT_COMMIT, 3'($urandom_range(7)), CMT_CTRL_AC);
        end
      end else if (pick < 82) begin
        add_word(ACT_CONTROL, 3'($urandom_range(7)), 8'($urandom_range(255)));
      end else begin
        cmt = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        add_word(3'($urandom_range(7)), 3'($urandom_range(7)), cmt);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (host_words_todo.size() != 0 || s_axis_tvalid || sound_words_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && sound_words_due.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
